/* rtl/core/tng_pkg.sv */
// Shared types, widths and helpers for the triangle normal generator.
// No dependencies; every other file refers to it by scoped names.
package tng_pkg;

	localparam int unsigned COORD_W = 20;
	localparam int unsigned EDGE_W  = 21;
	localparam int unsigned PROD_W  = 42;
	localparam int unsigned CROSS_W = 43;
	localparam int unsigned MAG_W   = 42;
	localparam int unsigned UNIT_W  = 30;
	localparam int unsigned SUM_W   = 62;
	localparam int unsigned ROOT_W  = 31;
	localparam int unsigned REM_W   = 33;
	localparam int unsigned NUM_W   = 45;
	localparam int unsigned QUO_W   = 15;
	localparam int unsigned NRM_W   = 16;
	localparam int unsigned IDX_W   = 16;

	localparam int unsigned DEF_NORMAL_STORE_DEPTH = 65536;

	// One triangle waiting for the back end: edge vectors and its index.
	typedef struct packed {
		logic signed [EDGE_W-1:0] e1x;
		logic signed [EDGE_W-1:0] e1y;
		logic signed [EDGE_W-1:0] e1z;
		logic signed [EDGE_W-1:0] e2x;
		logic signed [EDGE_W-1:0] e2y;
		logic signed [EDGE_W-1:0] e2z;
		logic [IDX_W-1:0]         index;
		logic                     full;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL,
		B_ABS,
		B_NORM,
		B_SQ,
		B_SQRT,
		B_DLOAD,
		B_DIV,
		B_OUT
	} back_state_t;

	// Last usable index for a given store depth.
	function automatic logic [IDX_W-1:0] last_index(input int unsigned depth);
		int unsigned last;
		last = depth - 1;
		if (last > 32'd65535) begin
			last = 32'd65535;
		end
		return last[IDX_W-1:0];
	endfunction

endpackage

/* rtl/core/tng_if.sv */
// Valid/ready channel interfaces for triangles in and normals out.
// Depends on tng_pkg for field widths.
interface tng_tri_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  needs_normal;
	logic signed [tng_pkg::COORD_W-1:0]    a_x;
	logic signed [tng_pkg::COORD_W-1:0]    a_y;
	logic signed [tng_pkg::COORD_W-1:0]    a_z;
	logic signed [tng_pkg::COORD_W-1:0]    b_x;
	logic signed [tng_pkg::COORD_W-1:0]    b_y;
	logic signed [tng_pkg::COORD_W-1:0]    b_z;
	logic signed [tng_pkg::COORD_W-1:0]    c_x;
	logic signed [tng_pkg::COORD_W-1:0]    c_y;
	logic signed [tng_pkg::COORD_W-1:0]    c_z;

	modport source (output valid, needs_normal, a_x, a_y, a_z, b_x, b_y, b_z,
		c_x, c_y, c_z, input ready);
	modport sink (input valid, needs_normal, a_x, a_y, a_z, b_x, b_y, b_z,
		c_x, c_y, c_z, output ready);
endinterface

interface tng_nrm_if;
	logic                                valid;
	logic                                ready;
	logic signed [tng_pkg::NRM_W-1:0]    normal_x;
	logic signed [tng_pkg::NRM_W-1:0]    normal_y;
	logic signed [tng_pkg::NRM_W-1:0]    normal_z;
	logic [tng_pkg::IDX_W-1:0]           normal_index;
	logic                                degenerate;
	logic                                store_full;

	modport source (output valid, normal_x, normal_y, normal_z, normal_index,
		degenerate, store_full, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, normal_index,
		degenerate, store_full, output ready);
endinterface

/* rtl/core/tng_front.sv */
// Front end: accepts triangle words, drops those that need no normal,
// forms edge vectors and hands out normal indices. Depends on tng_pkg.
module tng_front #(
	parameter int unsigned NORMAL_STORE_DEPTH = tng_pkg::DEF_NORMAL_STORE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tng_pkg::IDX_W-1:0]  cfg_data,
	tng_tri_if.sink                    triangle,
	output logic                       push,
	output tng_pkg::job_t              job,
	input  logic                       q_ready
);

	localparam logic [tng_pkg::IDX_W-1:0] LAST = tng_pkg::last_index(NORMAL_STORE_DEPTH);

	logic [tng_pkg::IDX_W-1:0] next_idx_q;
	logic                      full_q;
	logic                      full_new;

	assign triangle.ready = q_ready;
	assign push = triangle.valid && q_ready && triangle.needs_normal;

	// Edge vectors from the first vertex
	always_comb begin
		job.e1x = {triangle.b_x[19], triangle.b_x} - {triangle.a_x[19], triangle.a_x};
		job.e1y = {triangle.b_y[19], triangle.b_y} - {triangle.a_y[19], triangle.a_y};
		job.e1z = {triangle.b_z[19], triangle.b_z} - {triangle.a_z[19], triangle.a_z};
		job.e2x = {triangle.c_x[19], triangle.c_x} - {triangle.a_x[19], triangle.a_x};
		job.e2y = {triangle.c_y[19], triangle.c_y} - {triangle.a_y[19], triangle.a_y};
		job.e2z = {triangle.c_z[19], triangle.c_z} - {triangle.a_z[19], triangle.a_z};
		full_new  = full_q || (next_idx_q >= LAST);
		job.index = next_idx_q;
		job.full  = full_new;
	end

	// Advance the index counter; reload on a base write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_idx_q <= '0;
			full_q     <= 1'b0;
		end else if (cfg_we) begin
			next_idx_q <= (cfg_data > LAST) ? LAST : cfg_data;
			full_q     <= 1'b0;
		end else if (push && !full_q) begin
			if (next_idx_q >= LAST) begin
				full_q <= 1'b1;
			end else begin
				next_idx_q <= next_idx_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/core/tng_queue.sv */
// Two-entry queue of pending jobs between front and back end.
// Depends on tng_pkg for the job type.
module tng_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tng_pkg::job_t push_job,
	output logic          push_ready,
	input  logic          pop,
	output logic          pop_valid,
	output tng_pkg::job_t pop_job
);

	tng_pkg::job_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = slot_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push && push_ready) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push && push_ready, pop && pop_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/tng_back.sv */
// Back end: cross product, normalizing shift, square root and division
// over a shared cross-product multiplier, a squaring multiplier and iterative units. Depends on tng_pkg.
module tng_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  tng_pkg::job_t job,
	output logic          job_pop,
	tng_nrm_if.source     normal
);

	tng_pkg::back_state_t state_q, state_d;

	tng_pkg::job_t                        job_q;
	logic [2:0]                           cnt_q;
	logic [4:0]                           it_q;
	logic [1:0]                           comp_q;
	logic signed [tng_pkg::PROD_W-1:0]    prod_q;
	logic signed [tng_pkg::CROSS_W-1:0]   cross_q [3];
	logic [2:0]                           neg_q;
	logic [tng_pkg::MAG_W-1:0]            mag_q [3];
	logic [2*tng_pkg::UNIT_W-1:0]         sq_q;
	logic [tng_pkg::SUM_W-1:0]            sum_q;
	logic [tng_pkg::REM_W-1:0]            srem_q;
	logic [tng_pkg::ROOT_W-1:0]           root_q;
	logic [tng_pkg::ROOT_W:0]             drem_q;
	logic [tng_pkg::QUO_W-1:0]            dlow_q;
	logic [tng_pkg::QUO_W-1:0]            quo_q;
	logic signed [tng_pkg::NRM_W-1:0]     res_q [3];
	logic                                 degen_q;

	logic signed [tng_pkg::EDGE_W-1:0]    mul_a, mul_b;
	logic [tng_pkg::MAG_W-1:0]            mag_or;
	logic                                 norm_done;
	logic [tng_pkg::REM_W+1:0]            srem_sh;
	logic [tng_pkg::REM_W+1:0]            strial;
	logic [tng_pkg::NUM_W-1:0]            dnum;
	logic [tng_pkg::ROOT_W+1:0]           dr2;
	logic [tng_pkg::QUO_W:0]              quo_ext;

	// Operand select for the shared multiplier
	always_comb begin
		unique case (cnt_q)
			3'd0:    begin mul_a = job_q.e1y; mul_b = job_q.e2z; end
			3'd1:    begin mul_a = job_q.e1z; mul_b = job_q.e2y; end
			3'd2:    begin mul_a = job_q.e1z; mul_b = job_q.e2x; end
			3'd3:    begin mul_a = job_q.e1x; mul_b = job_q.e2z; end
			3'd4:    begin mul_a = job_q.e1x; mul_b = job_q.e2y; end
			default: begin mul_a = job_q.e1y; mul_b = job_q.e2x; end
		endcase
	end

	// Iteration datapath helpers
	always_comb begin
		mag_or    = mag_q[0] | mag_q[1] | mag_q[2];
		norm_done = (mag_or[tng_pkg::MAG_W-1:tng_pkg::UNIT_W] == '0) && mag_or[tng_pkg::UNIT_W-1];
		srem_sh   = {srem_q, sum_q[tng_pkg::SUM_W-1 -: 2]};
		strial    = {2'b00, root_q, 2'b01};
		dnum      = {1'b0, mag_q[comp_q][tng_pkg::UNIT_W-1:0], 14'd0}
			+ {{(tng_pkg::NUM_W-tng_pkg::ROOT_W+1){1'b0}}, root_q[tng_pkg::ROOT_W-1:1]};
		dr2       = {drem_q, dlow_q[tng_pkg::QUO_W-1]};
		quo_ext   = {1'b0, quo_q[tng_pkg::QUO_W-2:0], (dr2 >= {2'b00, root_q})};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tng_pkg::B_IDLE:  if (job_valid) state_d = tng_pkg::B_MUL;
			tng_pkg::B_MUL:   if (cnt_q == 3'd6) state_d = tng_pkg::B_ABS;
			tng_pkg::B_ABS:   state_d = tng_pkg::B_NORM;
			tng_pkg::B_NORM: begin
				if (mag_or == '0) state_d = tng_pkg::B_OUT;
				else if (norm_done) state_d = tng_pkg::B_SQ;
			end
			tng_pkg::B_SQ:    if (cnt_q == 3'd3) state_d = tng_pkg::B_SQRT;
			tng_pkg::B_SQRT:  if (it_q == 5'd30) state_d = tng_pkg::B_DLOAD;
			tng_pkg::B_DLOAD: state_d = tng_pkg::B_DIV;
			tng_pkg::B_DIV: begin
				if (it_q == 5'd14) begin
					state_d = (comp_q == 2'd2) ? tng_pkg::B_OUT : tng_pkg::B_DLOAD;
				end
			end
			tng_pkg::B_OUT:   if (normal.ready) state_d = tng_pkg::B_IDLE;
			default:          state_d = tng_pkg::B_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		job_pop      = (state_q == tng_pkg::B_IDLE);
		normal.valid = (state_q == tng_pkg::B_OUT);
	end

	assign normal.normal_x     = res_q[0];
	assign normal.normal_y     = res_q[1];
	assign normal.normal_z     = res_q[2];
	assign normal.normal_index = job_q.index;
	assign normal.degenerate   = degen_q;
	assign normal.store_full   = job_q.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tng_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath, one step per cycle of the current phase
	always_ff @(posedge clk) begin
		unique case (state_q)
			tng_pkg::B_IDLE: begin
				job_q   <= job;
				cnt_q   <= '0;
				degen_q <= 1'b0;
			end
			tng_pkg::B_MUL: begin
				// multiply now, fold the previous product into its component
				if (cnt_q != 3'd0) begin
					if (!cnt_q[0]) begin
						cross_q[cnt_q[2:1] - 2'd1] <= cross_q[cnt_q[2:1] - 2'd1]
							- {prod_q[tng_pkg::PROD_W-1], prod_q};
					end else begin
						cross_q[cnt_q[2:1]] <= {prod_q[tng_pkg::PROD_W-1], prod_q};
					end
				end
				prod_q <= mul_a * mul_b;
				cnt_q  <= cnt_q + 3'd1;
			end
			tng_pkg::B_ABS: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= cross_q[i][tng_pkg::CROSS_W-1];
					mag_q[i] <= cross_q[i][tng_pkg::CROSS_W-1]
						? tng_pkg::MAG_W'(-cross_q[i]) : tng_pkg::MAG_W'(cross_q[i]);
				end
			end
			tng_pkg::B_NORM: begin
				// bring the largest magnitude to a bit length of 30
				priority if (mag_or == '0) begin
					degen_q <= 1'b1;
					for (int i = 0; i < 3; i++) res_q[i] <= '0;
				end else if (mag_or[tng_pkg::MAG_W-1:tng_pkg::UNIT_W+4] != '0) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 4;
				end else if (mag_or[tng_pkg::UNIT_W+3:tng_pkg::UNIT_W] != '0) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else if (norm_done) begin
					cnt_q <= '0;
					sum_q <= '0;
				end else if (mag_or[tng_pkg::UNIT_W-1:tng_pkg::UNIT_W-4] == '0) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 4;
				end else begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
				end
			end
			tng_pkg::B_SQ: begin
				if (cnt_q != 3'd0) begin
					sum_q <= sum_q + {2'b00, sq_q};
				end
				if (cnt_q != 3'd3) begin
					sq_q <= mag_q[cnt_q[1:0]][tng_pkg::UNIT_W-1:0]
						* mag_q[cnt_q[1:0]][tng_pkg::UNIT_W-1:0];
				end
				cnt_q  <= cnt_q + 3'd1;
				srem_q <= '0;
				root_q <= '0;
				it_q   <= '0;
			end
			tng_pkg::B_SQRT: begin
				// one root bit per cycle, two radicand bits shifted in
				if (srem_sh >= strial) begin
					srem_q <= tng_pkg::REM_W'(srem_sh - strial);
					root_q <= {root_q[tng_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					srem_q <= srem_sh[tng_pkg::REM_W-1:0];
					root_q <= {root_q[tng_pkg::ROOT_W-2:0], 1'b0};
				end
				sum_q  <= sum_q << 2;
				it_q   <= it_q + 5'd1;
				comp_q <= '0;
			end
			tng_pkg::B_DLOAD: begin
				drem_q <= {2'b00, dnum[tng_pkg::NUM_W-1:tng_pkg::QUO_W]};
				dlow_q <= dnum[tng_pkg::QUO_W-1:0];
				quo_q  <= '0;
				it_q   <= '0;
			end
			tng_pkg::B_DIV: begin
				// one quotient bit per cycle
				if (dr2 >= {2'b00, root_q}) begin
					drem_q <= (tng_pkg::ROOT_W+1)'(dr2 - {2'b00, root_q});
				end else begin
					drem_q <= dr2[tng_pkg::ROOT_W:0];
				end
				dlow_q <= dlow_q << 1;
				quo_q  <= quo_ext[tng_pkg::QUO_W-1:0];
				it_q   <= it_q + 5'd1;
				if (it_q == 5'd14) begin
					res_q[comp_q] <= neg_q[comp_q]
						? tng_pkg::NRM_W'(-$signed(quo_ext)) : $signed(quo_ext);
					comp_q <= comp_q + 2'd1;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

endmodule

/* rtl/core/triangle_normal_generator.sv */
// Triangle normal generator: one result per triangle that lacks a normal.
// Each result takes 31 square-root steps, three divides and 0 to 8 normalizing shifts;
// a zero-length normal skips the square root and the divides. The back end works on one
// triangle at a time until its word is taken; up to two more wait in the queue.
// Triangles needing no normal are accepted while the queue has room. Async reset clears
// control state and the index counter to base 0.
module triangle_normal_generator #(
	parameter int unsigned NORMAL_STORE_DEPTH = tng_pkg::DEF_NORMAL_STORE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tng_pkg::IDX_W-1:0]  cfg_data,
	tng_tri_if.sink                    triangle,
	tng_nrm_if.source                  normal
);

	logic          push, q_ready, pop, pop_valid;
	tng_pkg::job_t push_job, pop_job;

	tng_front #(.NORMAL_STORE_DEPTH(NORMAL_STORE_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.triangle (triangle),
		.push     (push),
		.job      (push_job),
		.q_ready  (q_ready)
	);

	tng_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (q_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	tng_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job       (pop_job),
		.job_pop   (pop),
		.normal    (normal)
	);

endmodule

/* rtl/core/tng_checker.sv */
// Port-level checks on the normal output channel, bound to the top level.
// Depends on tng_pkg for widths.
module tng_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              valid,
	input logic                              ready,
	input logic signed [tng_pkg::NRM_W-1:0]  nx,
	input logic signed [tng_pkg::NRM_W-1:0]  ny,
	input logic signed [tng_pkg::NRM_W-1:0]  nz,
	input logic [tng_pkg::IDX_W-1:0]         idx,
	input logic                              degenerate
);

	// Hold a stalled word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(idx) && $stable(nx))
		else $error("output word dropped or changed under stall");

	// Degenerate words carry a zero vector
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		valid && degenerate |-> nx == 0 && ny == 0 && nz == 0)
		else $error("degenerate normal not zero");

	// Unit components stay within one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> nx <= 16384 && nx >= -16384 && ny <= 16384 && ny >= -16384
			&& nz <= 16384 && nz >= -16384)
		else $error("normal component out of range");

	// A real normal is never the zero vector
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !degenerate |-> nx != 0 || ny != 0 || nz != 0)
		else $error("non-degenerate normal is zero");

endmodule

bind triangle_normal_generator tng_checker u_tng_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (normal.valid),
	.ready      (normal.ready),
	.nx         (normal.normal_x),
	.ny         (normal.normal_y),
	.nz         (normal.normal_z),
	.idx        (normal.normal_index),
	.degenerate (normal.degenerate)
);
